/* rtl/core/mbd_pkg.sv */
// Shared types and constants of the multipart body deframer.
// Holds the phase, kind and register codes and the structs between modules.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package mbd_pkg;

  // Sizes of the boundary, the delimiter head and the match window.
  localparam int MAX_BOUNDARY     = 32;
  localparam int MAX_HEADER_BYTES = 4096;
  localparam int HEAD_LEN         = 4;
  localparam int WIN_DEPTH        = MAX_BOUNDARY + HEAD_LEN;
  localparam int CNT_W            = $clog2(WIN_DEPTH + 1);
  localparam int HDR_W            = $clog2(MAX_HEADER_BYTES + 1);
  localparam int BLEN_W           = 6;
  localparam int CFG_DATA_W       = 64;
  localparam int CFG_IDX_W        = 3;
  localparam int BB_REGS          = 4;
  localparam int BYTES_PER_REG    = CFG_DATA_W / 8;

  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(2);
  localparam logic [HDR_W-1:0] HDR_LIMIT = HDR_W'(MAX_HEADER_BYTES);
  localparam logic [7:0]       PART_MAX  = 8'd255;

  // Character codes of the delimiter and the header terminator.
  localparam logic [7:0] CHAR_CR   = 8'd13;
  localparam logic [7:0] CHAR_LF   = 8'd10;
  localparam logic [7:0] CHAR_DASH = 8'd45;

  // Header terminator tracking: delimiter CR LF seen, then CR LF CR.
  localparam logic [1:0] TRK_NONE  = 2'd0;
  localparam logic [1:0] TRK_CR    = 2'd1;
  localparam logic [1:0] TRK_CRLF  = 2'd2;
  localparam logic [1:0] TRK_CRLFCR = 2'd3;

  typedef enum logic [2:0] {
    KIND_HDR       = 3'd0,
    KIND_BODY      = 3'd1,
    KIND_CLOSED    = 3'd2,
    KIND_FINAL     = 3'd3,
    KIND_MALFORMED = 3'd4,
    KIND_OVERFLOW  = 3'd5,
    KIND_TRUNC     = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    PH_PREAMBLE = 3'd0,
    PH_PAIR1    = 3'd1,
    PH_PAIR2    = 3'd2,
    PH_HEADER   = 3'd3,
    PH_BODY     = 3'd4,
    PH_DONE     = 3'd5
  } phase_t;

  // Stage of the item in the hold register: main step, or end-of-stream flush.
  typedef enum logic {
    STG_MAIN  = 1'b0,
    STG_FLUSH = 1'b1
  } stage_t;

  // Operation that the engine performs in one cycle.
  typedef enum logic [1:0] {
    OP_IDLE    = 2'd0,
    OP_RELEASE = 2'd1,
    OP_MAIN    = 2'd2,
    OP_FINISH  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLEN = 3'd0,
    REG_BB0  = 3'd1,
    REG_BB1  = 3'd2,
    REG_BB2  = 3'd3,
    REG_BB3  = 3'd4
  } cfg_reg_t;

  // Delimiter as seen by the matcher: its length and all of its bytes.
  typedef struct packed {
    logic [CNT_W-1:0]          delim_len;
    logic [WIN_DEPTH-1:0][7:0] delim;
  } delim_cfg_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_t      kind;
    logic [7:0] part_index;
    logic       last_result;
  } result_t;

endpackage

`default_nettype wire

/* rtl/core/mbd_in_if.sv */
// Input channel of the deframer: one body byte and its end-of-stream flag.
// Valid/ready handshake; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface mbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, data_byte, end_of_stream, input ready);
  modport sink   (input valid, data_byte, end_of_stream, output ready);
endinterface

`default_nettype wire

/* rtl/core/mbd_out_if.sv */
// Output channel of the deframer: one result item per handshake.
// Valid/ready handshake; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface mbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] kind;
  logic [7:0] part_index;
  logic       last_result;

  modport source (output valid, out_byte, kind, part_index, last_result, input ready);
  modport sink   (input valid, out_byte, kind, part_index, last_result, output ready);
endinterface

`default_nettype wire

/* rtl/core/mbd_cfg.sv */
// Configuration registers of the deframer and the derived delimiter.
// Depends on mbd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbd_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [mbd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [mbd_pkg::CFG_DATA_W-1:0]   cfg_data,
  output mbd_pkg::delim_cfg_t                   delim_cfg
);

  logic [mbd_pkg::BLEN_W-1:0]     boundary_length;
  logic [mbd_pkg::CFG_DATA_W-1:0] boundary_bytes [mbd_pkg::BB_REGS];
  logic [mbd_pkg::BLEN_W-1:0]     blen_clamped;

  // Register writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      boundary_length <= mbd_pkg::BLEN_W'(1);
      for (int r = 0; r < mbd_pkg::BB_REGS; r++) begin
        boundary_bytes[r] <= '0;
      end
    end else if (cfg_we) begin
      unique case (mbd_pkg::cfg_reg_t'(cfg_index))
        mbd_pkg::REG_BLEN: boundary_length   <= cfg_data[mbd_pkg::BLEN_W-1:0];
        mbd_pkg::REG_BB0:  boundary_bytes[0] <= cfg_data;
        mbd_pkg::REG_BB1:  boundary_bytes[1] <= cfg_data;
        mbd_pkg::REG_BB2:  boundary_bytes[2] <= cfg_data;
        mbd_pkg::REG_BB3:  boundary_bytes[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Boundary length is used clamped to one through the maximum.
  always_comb begin
    if (boundary_length == '0) begin
      blen_clamped = mbd_pkg::BLEN_W'(1);
    end else if (boundary_length > mbd_pkg::BLEN_W'(mbd_pkg::MAX_BOUNDARY)) begin
      blen_clamped = mbd_pkg::BLEN_W'(mbd_pkg::MAX_BOUNDARY);
    end else begin
      blen_clamped = boundary_length;
    end
  end

  // Full delimiter: CR LF dash dash, then the boundary bytes in order.
  always_comb begin
    delim_cfg.delim_len = mbd_pkg::CNT_W'(blen_clamped) + mbd_pkg::CNT_W'(mbd_pkg::HEAD_LEN);
    delim_cfg.delim[0]  = mbd_pkg::CHAR_CR;
    delim_cfg.delim[1]  = mbd_pkg::CHAR_LF;
    delim_cfg.delim[2]  = mbd_pkg::CHAR_DASH;
    delim_cfg.delim[3]  = mbd_pkg::CHAR_DASH;
    for (int i = 0; i < mbd_pkg::MAX_BOUNDARY; i++) begin
      delim_cfg.delim[mbd_pkg::HEAD_LEN + i] =
        boundary_bytes[i / mbd_pkg::BYTES_PER_REG][8 * (i % mbd_pkg::BYTES_PER_REG) +: 8];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/mbd_engine.sv */
// Deframing engine: hold register, match window, phase control and counters.
// Produces at most one result per cycle. Depends on mbd_pkg and mbd_in_if.
`timescale 1ns / 1ps
`default_nettype none

module mbd_engine (
  input  wire logic                clk,
  input  wire logic                rst,
  mbd_in_if.sink                   body_in,
  input  wire mbd_pkg::delim_cfg_t delim_cfg,
  input  wire logic                out_free,
  output logic                     res_valid,
  output mbd_pkg::result_t         res
);

  localparam int WD = mbd_pkg::WIN_DEPTH;
  localparam int CW = mbd_pkg::CNT_W;

  // Item hold register.
  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       hold_eos;

  // Stream state.
  mbd_pkg::phase_t        phase, phase_main, phase_next;
  mbd_pkg::stage_t        stage;
  logic [7:0]             win [WD];
  logic [7:0]             ins [WD];
  logic [7:0]             win_sh [WD];
  logic [7:0]             ins_sh [WD];
  logic [CW-1:0]          count;
  logic [7:0]             pair_first;
  logic [1:0]             header_end_track;
  logic [mbd_pkg::HDR_W-1:0] header_bytes_seen;
  logic [7:0]             part_counter;

  // Step decode.
  mbd_pkg::op_t op;
  logic [CW-1:0] fill;
  logic win_phase, excess, full, hit;
  logic pair_dash, pair_crlf, hdr_over, hdr_end;
  logic emit, advance, item_done, in_ready;

  assign win_phase = (phase == mbd_pkg::PH_PREAMBLE) || (phase == mbd_pkg::PH_BODY);
  assign excess    = win_phase && (count >= delim_cfg.delim_len);
  assign fill      = count + mbd_pkg::CNT_ONE;
  assign full      = (fill == delim_cfg.delim_len);
  assign pair_dash = (pair_first == mbd_pkg::CHAR_DASH) && (hold_byte == mbd_pkg::CHAR_DASH);
  assign pair_crlf = (pair_first == mbd_pkg::CHAR_CR) && (hold_byte == mbd_pkg::CHAR_LF);
  assign hdr_over  = (header_bytes_seen >= mbd_pkg::HDR_LIMIT);
  assign hdr_end   = !hdr_over && (hold_byte == mbd_pkg::CHAR_LF) &&
                     (header_end_track == mbd_pkg::TRK_CRLFCR);

  // Window with the new byte placed, and both shifted by one entry.
  always_comb begin
    for (int i = 0; i < WD; i++) begin
      ins[i] = (count == CW'(i)) ? hold_byte : win[i];
    end
    for (int i = 0; i < WD - 1; i++) begin
      win_sh[i] = win[i + 1];
      ins_sh[i] = ins[i + 1];
    end
    win_sh[WD-1] = win[WD-1];
    ins_sh[WD-1] = ins[WD-1];
  end

  // Delimiter compare over the filled part of the window.
  always_comb begin
    hit = 1'b1;
    for (int k = 0; k < WD; k++) begin
      if ((CW'(k) < delim_cfg.delim_len) && (ins[k] != delim_cfg.delim[k])) begin
        hit = 1'b0;
      end
    end
  end

  // Operation for this cycle: release excess bytes before the main step,
  // and after an end-of-stream item flush the window and then finish.
  always_comb begin
    if (!hold_valid) begin
      op = mbd_pkg::OP_IDLE;
    end else if (stage == mbd_pkg::STG_MAIN) begin
      op = excess ? mbd_pkg::OP_RELEASE : mbd_pkg::OP_MAIN;
    end else if ((phase == mbd_pkg::PH_BODY) && (count != '0)) begin
      op = mbd_pkg::OP_RELEASE;
    end else begin
      op = mbd_pkg::OP_FINISH;
    end
  end

  // Phase after the main step, and the phase next state.
  always_comb begin
    phase_main = phase;
    unique case (phase) inside
      mbd_pkg::PH_PREAMBLE, mbd_pkg::PH_BODY: begin
        if (full && hit) phase_main = mbd_pkg::PH_PAIR1;
      end
      mbd_pkg::PH_PAIR1: phase_main = mbd_pkg::PH_PAIR2;
      mbd_pkg::PH_PAIR2: begin
        if (pair_dash) phase_main = mbd_pkg::PH_DONE;
        else if (pair_crlf) phase_main = mbd_pkg::PH_HEADER;
        else phase_main = mbd_pkg::PH_DONE;
      end
      mbd_pkg::PH_HEADER: begin
        if (hdr_over) phase_main = mbd_pkg::PH_DONE;
        else if (hdr_end) phase_main = mbd_pkg::PH_BODY;
      end
      mbd_pkg::PH_DONE: phase_main = mbd_pkg::PH_DONE;
      default: phase_main = mbd_pkg::PH_DONE;
    endcase

    phase_next = phase;
    if (advance) begin
      case (op)
        mbd_pkg::OP_MAIN:   phase_next = phase_main;
        mbd_pkg::OP_FINISH: phase_next = mbd_pkg::PH_PREAMBLE;
        default: ;
      endcase
    end
  end

  // Result of this cycle.
  always_comb begin
    emit            = 1'b0;
    res.out_byte    = '0;
    res.kind        = mbd_pkg::KIND_BODY;
    res.part_index  = part_counter;
    res.last_result = 1'b0;
    unique case (op)
      mbd_pkg::OP_RELEASE: begin
        emit         = (phase == mbd_pkg::PH_BODY);
        res.out_byte = win[0];
      end
      mbd_pkg::OP_MAIN: begin
        // An end-of-stream item still owes a truncation result unless finished.
        res.last_result = !(hold_eos && (phase_main != mbd_pkg::PH_DONE));
        case (phase)
          mbd_pkg::PH_BODY: begin
            emit = full;
            if (hit) res.kind = mbd_pkg::KIND_CLOSED;
            else res.out_byte = ins[0];
          end
          mbd_pkg::PH_PAIR2: begin
            emit = !pair_crlf;
            res.kind = pair_dash ? mbd_pkg::KIND_FINAL : mbd_pkg::KIND_MALFORMED;
          end
          mbd_pkg::PH_HEADER: begin
            emit = 1'b1;
            if (hdr_over) begin
              res.kind = mbd_pkg::KIND_OVERFLOW;
            end else begin
              res.kind     = mbd_pkg::KIND_HDR;
              res.out_byte = hold_byte;
            end
          end
          default: ;
        endcase
      end
      mbd_pkg::OP_FINISH: begin
        emit            = (phase != mbd_pkg::PH_DONE);
        res.kind        = mbd_pkg::KIND_TRUNC;
        res.last_result = 1'b1;
      end
      default: ;
    endcase
  end

  // Handshake: a step that emits waits for the result register.
  assign advance   = hold_valid && (!emit || out_free);
  assign item_done = advance && (((op == mbd_pkg::OP_MAIN) && !hold_eos) ||
                                 (op == mbd_pkg::OP_FINISH));
  assign in_ready  = !hold_valid || item_done;
  assign body_in.ready = in_ready;
  assign res_valid = emit && advance;

  // Hold register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= body_in.valid;
    end
    if (in_ready && body_in.valid) begin
      hold_byte <= body_in.data_byte;
      hold_eos  <= body_in.end_of_stream;
    end
  end

  // Phase and stage registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= mbd_pkg::PH_PREAMBLE;
      stage <= mbd_pkg::STG_MAIN;
    end else begin
      phase <= phase_next;
      if (advance && (op == mbd_pkg::OP_MAIN) && hold_eos) stage <= mbd_pkg::STG_FLUSH;
      else if (advance && (op == mbd_pkg::OP_FINISH)) stage <= mbd_pkg::STG_MAIN;
    end
  end

  // Match window; a new stream starts with the assumed CR LF.
  always_ff @(posedge clk) begin
    if (rst) begin
      win[0] <= mbd_pkg::CHAR_CR;
      win[1] <= mbd_pkg::CHAR_LF;
    end else if (advance) begin
      case (op)
        mbd_pkg::OP_RELEASE: win <= win_sh;
        mbd_pkg::OP_MAIN: begin
          if (win_phase) begin
            if (!full) win <= ins;
            else if (!hit) win <= ins_sh;
          end
        end
        mbd_pkg::OP_FINISH: begin
          win[0] <= mbd_pkg::CHAR_CR;
          win[1] <= mbd_pkg::CHAR_LF;
        end
        default: ;
      endcase
    end
  end

  // Window fill count, header tracking and part counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      count             <= mbd_pkg::CNT_RESET;
      pair_first        <= '0;
      header_end_track  <= mbd_pkg::TRK_NONE;
      header_bytes_seen <= '0;
      part_counter      <= '0;
    end else if (advance) begin
      case (op)
        mbd_pkg::OP_RELEASE: count <= count - mbd_pkg::CNT_ONE;
        mbd_pkg::OP_MAIN: begin
          case (phase)
            mbd_pkg::PH_PREAMBLE, mbd_pkg::PH_BODY: begin
              if (!full) begin
                count <= fill;
              end else if (hit) begin
                count <= '0;
                if ((phase == mbd_pkg::PH_BODY) && (part_counter != mbd_pkg::PART_MAX)) begin
                  part_counter <= part_counter + 8'd1;
                end
              end
            end
            mbd_pkg::PH_PAIR1: pair_first <= hold_byte;
            mbd_pkg::PH_PAIR2: begin
              if (pair_crlf) begin
                header_end_track  <= mbd_pkg::TRK_CRLF;
                header_bytes_seen <= '0;
              end
            end
            mbd_pkg::PH_HEADER: begin
              if (!hdr_over) begin
                header_bytes_seen <= header_bytes_seen + mbd_pkg::HDR_W'(1);
                if (hold_byte == mbd_pkg::CHAR_CR) begin
                  header_end_track <= (header_end_track == mbd_pkg::TRK_CRLF) ?
                                      mbd_pkg::TRK_CRLFCR : mbd_pkg::TRK_CR;
                end else if (hold_byte == mbd_pkg::CHAR_LF) begin
                  if (hdr_end) begin
                    count            <= '0;
                    header_end_track <= mbd_pkg::TRK_NONE;
                  end else begin
                    header_end_track <= (header_end_track == mbd_pkg::TRK_CR) ?
                                        mbd_pkg::TRK_CRLF : mbd_pkg::TRK_NONE;
                  end
                end else begin
                  header_end_track <= mbd_pkg::TRK_NONE;
                end
              end
            end
            default: ;
          endcase
        end
        mbd_pkg::OP_FINISH: begin
          count             <= mbd_pkg::CNT_RESET;
          pair_first        <= '0;
          header_end_track  <= mbd_pkg::TRK_NONE;
          header_bytes_seen <= '0;
          part_counter      <= '0;
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/mbd_out_reg.sv */
// Result register of the deframer, driving the output channel.
// Depends on mbd_pkg and mbd_out_if.
`timescale 1ns / 1ps
`default_nettype none

module mbd_out_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             res_valid,
  input  wire mbd_pkg::result_t res,
  output logic                  out_free,
  mbd_out_if.source             result_out
);

  logic             valid;
  mbd_pkg::result_t data;

  // The register takes a new result whenever it is empty or being drained.
  assign out_free = !valid || result_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (out_free) begin
      valid <= res_valid;
    end
    if (out_free && res_valid) begin
      data <= res;
    end
  end

  assign result_out.valid       = valid;
  assign result_out.out_byte    = data.out_byte;
  assign result_out.kind        = data.kind;
  assign result_out.part_index  = data.part_index;
  assign result_out.last_result = data.last_result;

endmodule

`default_nettype wire

/* rtl/core/multipart_body_deframer_top.sv */
// Multipart body deframer. Takes one body byte per item and splits the body at
// CR LF dash dash boundary, passing header bytes and body bytes on with their part
// index and flagging part ends, the closing delimiter, malformed streams, header
// overflow and truncation. One item per cycle is sustained while the output is
// drained every cycle and no byte causes extra results; the single result
// register takes at most one result per cycle. A byte that causes several
// results holds the input until its last step: an end-of-stream byte takes its
// own step, a release step per flushed window byte and a finish step, and the
// first byte after a shorter boundary is written takes a release step per
// surplus window byte first. The user must write the boundary registers only
// while the block is idle; the block itself does not enforce this. Depends on
// mbd_pkg, both channel interfaces, mbd_cfg, mbd_engine and mbd_out_reg.
`timescale 1ns / 1ps
`default_nettype none

module multipart_body_deframer_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  mbd_in_if.sink                              body_in,
  mbd_out_if.source                           result_out,
  input  wire logic                           cfg_we,
  input  wire logic [mbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mbd_pkg::CFG_DATA_W-1:0] cfg_data
);

  mbd_pkg::delim_cfg_t delim_cfg;
  mbd_pkg::result_t    res;
  logic                res_valid;
  logic                out_free;

  // Configuration registers.
  mbd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .delim_cfg (delim_cfg)
  );

  // Deframing engine.
  mbd_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .body_in   (body_in),
    .delim_cfg (delim_cfg),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register.
  mbd_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .res_valid  (res_valid),
    .res        (res),
    .out_free   (out_free),
    .result_out (result_out)
  );

  // The hold register is empty after reset, so the block takes an item at once.
  a_ready_after_reset: assert property (@(posedge clk) rst |=> body_in.ready)
    else $error("input not ready after reset");

  // Event results carry no byte.
  a_event_byte_zero: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && (result_out.kind != mbd_pkg::KIND_HDR) &&
    (result_out.kind != mbd_pkg::KIND_BODY) |-> (result_out.out_byte == 8'd0))
    else $error("event result with nonzero byte");

  // Results that finish a stream are always the last of their item.
  a_finish_is_last: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && ((result_out.kind == mbd_pkg::KIND_FINAL) ||
    (result_out.kind == mbd_pkg::KIND_MALFORMED) ||
    (result_out.kind == mbd_pkg::KIND_OVERFLOW) ||
    (result_out.kind == mbd_pkg::KIND_TRUNC)) |-> result_out.last_result)
    else $error("stream-ending result not marked last");

endmodule

`default_nettype wire
